@@ hdl/mm4_pkg.sv @@
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared sizes, operation codes and the item record for the 4x4 matrix
// multiplier cell chain.
// ----------------------------------------------------------------------------
package mm4_pkg;

	localparam int DIM        = 4;
	localparam int FRAC_BITS  = 12;
	localparam int ELEM_W     = 16;
	localparam int COL_W      = 2;
	localparam int NUM_FIELDS = 4;
	localparam int IDX_W      = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int PROD_W     = 2 * ELEM_W;
	localparam int ACC_W      = PROD_W + $clog2(DIM);

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_MUL  = 1'b1
	} op_t;

	typedef struct packed {
		op_t                          op;
		logic [COL_W-1:0]             col;
		logic [DIM-1:0][ELEM_W-1:0]   elem;
		logic [DIM-1:0][ACC_W-1:0]    acc;
	} item_t;

endpackage

@@ hdl/mm4_cell.sv @@
// ----------------------------------------------------------------------------
// mm4_cell
// One cell of the chain: holds one column of A, adds its share of the dot
// products to the partial sums and hands the item to the next cell.
// ----------------------------------------------------------------------------
module mm4_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [mm4_pkg::IDX_W-1:0] idx,
	input  logic                      up_valid,
	output logic                      up_ready,
	input  mm4_pkg::item_t            up_item,
	output logic                      dn_valid,
	input  logic                      dn_ready,
	output mm4_pkg::item_t            dn_item
);

	logic [mm4_pkg::DIM-1:0][mm4_pkg::ELEM_W-1:0] a_col_q;
	logic                                          vld_s1;
	mm4_pkg::item_t                                item_s1;
	mm4_pkg::item_t                                item_d;
	logic                                          take;
	logic                                          hit_load;
	logic signed [mm4_pkg::ELEM_W-1:0]             b_elem;
	logic signed [mm4_pkg::PROD_W-1:0]             prod [mm4_pkg::DIM];

	assign up_ready = !vld_s1 || dn_ready;
	assign take     = up_valid && up_ready;
	assign hit_load = (up_item.op == mm4_pkg::OP_LOAD) && (int'(up_item.col) == int'(idx));
	assign b_elem   = $signed(up_item.elem[idx]);

	always_comb begin
		item_d = up_item;
		for (int r = 0; r < mm4_pkg::DIM; r++) begin
			prod[r]       = $signed(a_col_q[r]) * b_elem;
			item_d.acc[r] = $signed(up_item.acc[r]) + mm4_pkg::ACC_W'(prod[r]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (up_ready) begin
			vld_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
		if (take && hit_load) begin
			a_col_q <= up_item.elem;
		end
	end

	assign dn_valid = vld_s1;
	assign dn_item  = item_s1;

endmodule

@@ hdl/mm4_round.sv @@
// ----------------------------------------------------------------------------
// mm4_round
// End of the chain: rounds and saturates the finished sums and holds the
// result item in the output register. Load items are dropped here.
// ----------------------------------------------------------------------------
module mm4_round (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               up_valid,
	output logic                               up_ready,
	input  mm4_pkg::item_t                     up_item,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output logic [mm4_pkg::COL_W-1:0]          rsp_col,
	output logic [mm4_pkg::NUM_FIELDS-1:0][mm4_pkg::ELEM_W-1:0] rsp_res,
	output logic                               rsp_clipped
);

	localparam int T_W = mm4_pkg::ACC_W + 1;
	localparam int Q_W = T_W - mm4_pkg::FRAC_BITS;
	localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32'sd32767);
	localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-32'sd32768);
	localparam logic signed [T_W-1:0] HALF  = T_W'(1) <<< (mm4_pkg::FRAC_BITS - 1);

	logic                                                    out_valid_q;
	logic [mm4_pkg::COL_W-1:0]                               out_col_q;
	logic [mm4_pkg::NUM_FIELDS-1:0][mm4_pkg::ELEM_W-1:0]     out_res_q;
	logic                                                    out_clip_q;
	logic [mm4_pkg::NUM_FIELDS-1:0][mm4_pkg::ELEM_W-1:0]     res_d;
	logic [mm4_pkg::NUM_FIELDS-1:0]                          clip_row;
	logic                                                    col_ok;
	logic                                                    take;

	assign up_ready = !out_valid_q || !rsp_stall;
	assign take     = up_valid && up_ready && (up_item.op == mm4_pkg::OP_MUL);
	assign col_ok   = int'(up_item.col) < mm4_pkg::DIM;

	for (genvar r = 0; r < mm4_pkg::NUM_FIELDS; r++) begin : g_row
		if (r < mm4_pkg::DIM) begin : g_live
			logic signed [T_W-1:0] t;
			logic signed [Q_W-1:0] q;
			always_comb begin
				t = T_W'($signed(up_item.acc[r])) + HALF;
				q = Q_W'(t >>> mm4_pkg::FRAC_BITS);
				clip_row[r] = 1'b0;
				if (!col_ok) begin
					res_d[r] = '0;
				end else if (q > Q_MAX) begin
					res_d[r]    = 16'h7fff;
					clip_row[r] = 1'b1;
				end else if (q < Q_MIN) begin
					res_d[r]    = 16'h8000;
					clip_row[r] = 1'b1;
				end else begin
					res_d[r] = q[mm4_pkg::ELEM_W-1:0];
				end
			end
		end else begin : g_dead
			assign res_d[r]    = '0;
			assign clip_row[r] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (up_ready) begin
			out_valid_q <= up_valid && (up_item.op == mm4_pkg::OP_MUL);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_col_q  <= up_item.col;
			out_res_q  <= res_d;
			out_clip_q <= |clip_row;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign rsp_col     = out_col_q;
	assign rsp_res     = out_res_q;
	assign rsp_clipped = out_clip_q;

endmodule

@@ hdl/matrix4x4_multiply.sv @@
// ----------------------------------------------------------------------------
// matrix4x4_multiply
// Column-major fixed-point product A*B, one column of B per item, on a
// chain of cells that each hold one column of A.
//
//   channel  handshake           payload
//   req      req_valid/req_stall op, col, elem0..elem3
//   rsp      rsp_valid/rsp_stall out_col, res0..res3, clipped
//
// One item per cycle sustained while rsp_stall is low; a multiply's result is
// registered in each cell in turn and then in the round/saturate register.
// Loads travel the chain too, so each cell sees loads and multiplies in order.
// Reset clears only the valid bits; A is undefined until its columns are loaded.
// rsp_stall fills pipeline bubbles first; req_stall rises once the chain is full.
// ----------------------------------------------------------------------------
module matrix4x4_multiply (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic        op,
	input  logic [1:0]  col,
	input  logic signed [15:0] elem0,
	input  logic signed [15:0] elem1,
	input  logic signed [15:0] elem2,
	input  logic signed [15:0] elem3,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  out_col,
	output logic signed [15:0] res0,
	output logic signed [15:0] res1,
	output logic signed [15:0] res2,
	output logic signed [15:0] res3,
	output logic        clipped
);

	mm4_pkg::item_t chain_item  [mm4_pkg::DIM+1];
	logic           chain_valid [mm4_pkg::DIM+1];
	logic           chain_ready [mm4_pkg::DIM+1];
	logic [mm4_pkg::NUM_FIELDS-1:0][mm4_pkg::ELEM_W-1:0] elem_w;
	logic [mm4_pkg::NUM_FIELDS-1:0][mm4_pkg::ELEM_W-1:0] res_w;

	assign elem_w = {elem3, elem2, elem1, elem0};

	assign chain_item[0].op  = mm4_pkg::op_t'(op);
	assign chain_item[0].col = col;
	assign chain_item[0].acc = '0;
	for (genvar r = 0; r < mm4_pkg::DIM; r++) begin : g_in
		if (r < mm4_pkg::NUM_FIELDS) begin : g_field
			assign chain_item[0].elem[r] = elem_w[r];
		end else begin : g_zero
			assign chain_item[0].elem[r] = '0;
		end
	end
	assign chain_valid[0] = req_valid;
	assign req_stall      = !chain_ready[0];

	for (genvar k = 0; k < mm4_pkg::DIM; k++) begin : g_cell
		mm4_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (mm4_pkg::IDX_W'(k)),
			.up_valid (chain_valid[k]),
			.up_ready (chain_ready[k]),
			.up_item  (chain_item[k]),
			.dn_valid (chain_valid[k+1]),
			.dn_ready (chain_ready[k+1]),
			.dn_item  (chain_item[k+1])
		);
	end

	mm4_round u_round (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (chain_valid[mm4_pkg::DIM]),
		.up_ready    (chain_ready[mm4_pkg::DIM]),
		.up_item     (chain_item[mm4_pkg::DIM]),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.rsp_col     (out_col),
		.rsp_res     (res_w),
		.rsp_clipped (clipped)
	);

	assign res0 = res_w[0];
	assign res1 = res_w[1];
	assign res2 = res_w[2];
	assign res3 = res_w[3];

endmodule

@@ hdl/mm4_checker.sv @@
// ----------------------------------------------------------------------------
// mm4_checker
// Port-level checks on the matrix multiplier, bound to the top level.
// ----------------------------------------------------------------------------
module mm4_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_stall,
	input logic [1:0]  out_col,
	input logic signed [15:0] res0,
	input logic signed [15:0] res1,
	input logic signed [15:0] res2,
	input logic signed [15:0] res3,
	input logic        clipped
);

	a_no_rsp_in_reset: assert property (@(posedge clk) !arst_n |-> !rsp_valid)
		else $error("result item valid during reset");

	a_rsp_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("stalled result item dropped");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(out_col) && $stable(res0) && $stable(res1)
			&& $stable(res2) && $stable(res3) && $stable(clipped))
		else $error("stalled result item changed");

	a_clip_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && clipped |->
			(res0 == 16'sh7fff || res0 == 16'sh8000 || res1 == 16'sh7fff
			|| res1 == 16'sh8000 || res2 == 16'sh7fff || res2 == 16'sh8000
			|| res3 == 16'sh7fff || res3 == 16'sh8000))
		else $error("clipped flag set with no element at a limit");

endmodule

bind matrix4x4_multiply mm4_checker u_mm4_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.out_col   (out_col),
	.res0      (res0),
	.res1      (res1),
	.res2      (res2),
	.res3      (res3),
	.clipped   (clipped)
);
